// ===== hdl/prp_pkg.sv =====
// ----------------------------------------------------------------------------
// Planar rotation package
// Shared types and constants: pipeline control word, CORDIC word format and
// the table of elementary rotation angles in 2^-32 turn units.
// ----------------------------------------------------------------------------
package prp_pkg;

    localparam int CORDIC_WIDTH = 32;
    localparam int FRAC_BITS    = 30;
    localparam int MAX_STAGES   = 32;

    localparam logic signed [CORDIC_WIDTH-1:0] GAIN_Q30     = 32'sd652032874;
    localparam logic signed [CORDIC_WIDTH-1:0] QUARTER_TURN = 32'sd1073741824;

    localparam logic signed [CORDIC_WIDTH-1:0] ATAN_TURN32 [MAX_STAGES] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
        32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
        32'sd652,       32'sd326,       32'sd163,       32'sd81,
        32'sd41,        32'sd20,        32'sd10,        32'sd5,
        32'sd3,         32'sd1,         32'sd1,         32'sd0
    };

    typedef struct packed {
        logic valid;
        logic flip;
        logic partner;
        logic last;
    } ctrl_t;

endpackage

// ===== hdl/prp_pair_if.sv =====
// ----------------------------------------------------------------------------
// Coordinate pair channel
// Valid/ready channel carrying one coordinate pair and its rotation angle.
// ----------------------------------------------------------------------------
interface prp_pair_if #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int ANGLE_WIDTH  = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] first_value;
    logic signed [SAMPLE_WIDTH-1:0] second_value;
    logic signed [ANGLE_WIDTH-1:0]  rotation_angle;
    logic                           has_partner;
    logic                           last_of_vector;

    modport source (
        output valid, first_value, second_value, rotation_angle, has_partner,
               last_of_vector,
        input  ready
    );

    modport sink (
        input  valid, first_value, second_value, rotation_angle, has_partner,
               last_of_vector,
        output ready
    );
endinterface

// ===== hdl/prp_result_if.sv =====
// ----------------------------------------------------------------------------
// Rotated pair channel
// Valid/ready channel carrying one rotated coordinate pair and its flags.
// ----------------------------------------------------------------------------
interface prp_result_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] rotated_first;
    logic signed [SAMPLE_WIDTH-1:0] rotated_second;
    logic                           partner_valid;
    logic                           saturated;
    logic                           end_of_vector;

    modport source (
        output valid, rotated_first, rotated_second, partner_valid, saturated,
               end_of_vector,
        input  ready
    );

    modport sink (
        input  valid, rotated_first, rotated_second, partner_valid, saturated,
               end_of_vector,
        output ready
    );
endinterface

// ===== hdl/prp_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// CORDIC rotation cell
// One micro-rotation by a fixed elementary angle, registered, with the item's
// samples and control carried alongside.
// ----------------------------------------------------------------------------
module prp_cordic_cell #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int SHIFT        = 0
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     advance,
    input  prp_pkg::ctrl_t                           ctrl_up,
    input  logic signed [prp_pkg::CORDIC_WIDTH-1:0]  x_up,
    input  logic signed [prp_pkg::CORDIC_WIDTH-1:0]  y_up,
    input  logic signed [prp_pkg::CORDIC_WIDTH-1:0]  z_up,
    input  logic signed [SAMPLE_WIDTH-1:0]           first_up,
    input  logic signed [SAMPLE_WIDTH-1:0]           second_up,
    output prp_pkg::ctrl_t                           ctrl_dn,
    output logic signed [prp_pkg::CORDIC_WIDTH-1:0]  x_dn,
    output logic signed [prp_pkg::CORDIC_WIDTH-1:0]  y_dn,
    output logic signed [prp_pkg::CORDIC_WIDTH-1:0]  z_dn,
    output logic signed [SAMPLE_WIDTH-1:0]           first_dn,
    output logic signed [SAMPLE_WIDTH-1:0]           second_dn
);
    import prp_pkg::*;

    localparam logic signed [CORDIC_WIDTH-1:0] STEP_ANGLE = ATAN_TURN32[SHIFT];

    ctrl_t                          ctrl_reg;
    logic signed [CORDIC_WIDTH-1:0] x_reg;
    logic signed [CORDIC_WIDTH-1:0] y_reg;
    logic signed [CORDIC_WIDTH-1:0] z_reg;
    logic signed [CORDIC_WIDTH-1:0] x_next;
    logic signed [CORDIC_WIDTH-1:0] y_next;
    logic signed [CORDIC_WIDTH-1:0] z_next;
    logic signed [SAMPLE_WIDTH-1:0] first_reg;
    logic signed [SAMPLE_WIDTH-1:0] second_reg;

    // A residual of zero rotates in the positive direction.
    always_comb
    begin
        if (!z_up[CORDIC_WIDTH-1])
        begin
            x_next = x_up - (y_up >>> SHIFT);
            y_next = y_up + (x_up >>> SHIFT);
            z_next = z_up - STEP_ANGLE;
        end
        else
        begin
            x_next = x_up + (y_up >>> SHIFT);
            y_next = y_up - (x_up >>> SHIFT);
            z_next = z_up + STEP_ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (advance)
        begin
            ctrl_reg <= ctrl_up;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_reg      <= x_next;
            y_reg      <= y_next;
            z_reg      <= z_next;
            first_reg  <= first_up;
            second_reg <= second_up;
        end
    end

    assign ctrl_dn   = ctrl_reg;
    assign x_dn      = x_reg;
    assign y_dn      = y_reg;
    assign z_dn      = z_reg;
    assign first_dn  = first_reg;
    assign second_dn = second_reg;

endmodule

// ===== hdl/prp_rotate.sv =====
// ----------------------------------------------------------------------------
// Pair rotation back end
// Applies the half-turn correction to cosine and sine, forms four products,
// then rounds and saturates both coordinates; an unpartnered second is zero.
// ----------------------------------------------------------------------------
module prp_rotate #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     advance,
    input  prp_pkg::ctrl_t                           ctrl_up,
    input  logic signed [prp_pkg::CORDIC_WIDTH-1:0]  cos_up,
    input  logic signed [prp_pkg::CORDIC_WIDTH-1:0]  sin_up,
    input  logic signed [SAMPLE_WIDTH-1:0]           first_up,
    input  logic signed [SAMPLE_WIDTH-1:0]           second_up,
    output logic                                     valid_dn,
    output logic signed [SAMPLE_WIDTH-1:0]           rotated_first,
    output logic signed [SAMPLE_WIDTH-1:0]           rotated_second,
    output logic                                     partner_valid,
    output logic                                     saturated,
    output logic                                     end_of_vector
);
    import prp_pkg::*;

    localparam int PROD_WIDTH = SAMPLE_WIDTH + CORDIC_WIDTH;
    localparam int SUM_WIDTH  = PROD_WIDTH + 1;
    localparam int RES_WIDTH  = SUM_WIDTH - FRAC_BITS;
    localparam logic signed [SUM_WIDTH-1:0]    ROUND_BIAS = SUM_WIDTH'(1 << (FRAC_BITS - 1));
    localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MIN    = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MAX    = ~SAT_MIN;

    ctrl_t                          ctrl_a_reg;
    logic signed [CORDIC_WIDTH-1:0] cos_a_reg;
    logic signed [CORDIC_WIDTH-1:0] sin_a_reg;
    logic signed [SAMPLE_WIDTH-1:0] first_a_reg;
    logic signed [SAMPLE_WIDTH-1:0] second_a_reg;

    ctrl_t                          ctrl_b_reg;
    logic signed [PROD_WIDTH-1:0]   first_cos_reg;
    logic signed [PROD_WIDTH-1:0]   first_sin_reg;
    logic signed [PROD_WIDTH-1:0]   second_cos_reg;
    logic signed [PROD_WIDTH-1:0]   second_sin_reg;

    ctrl_t                          ctrl_c_reg;
    logic signed [SAMPLE_WIDTH-1:0] first_c_reg;
    logic signed [SAMPLE_WIDTH-1:0] second_c_reg;
    logic                           sat_c_reg;

    logic signed [SUM_WIDTH-1:0]    sum_first;
    logic signed [SUM_WIDTH-1:0]    sum_second;
    logic signed [RES_WIDTH-1:0]    res_first;
    logic signed [RES_WIDTH-1:0]    res_second;
    logic [RES_WIDTH-SAMPLE_WIDTH:0] top_first;
    logic [RES_WIDTH-SAMPLE_WIDTH:0] top_second;
    logic                           clip_first;
    logic                           clip_second;
    logic signed [SAMPLE_WIDTH-1:0] first_next;
    logic signed [SAMPLE_WIDTH-1:0] second_next;
    logic                           sat_next;

    always_comb
    begin
        sum_first  = SUM_WIDTH'(first_cos_reg) - SUM_WIDTH'(second_sin_reg) + ROUND_BIAS;
        sum_second = SUM_WIDTH'(first_sin_reg) + SUM_WIDTH'(second_cos_reg) + ROUND_BIAS;
        res_first  = sum_first[SUM_WIDTH-1:FRAC_BITS];
        res_second = sum_second[SUM_WIDTH-1:FRAC_BITS];
        top_first  = res_first[RES_WIDTH-1:SAMPLE_WIDTH-1];
        top_second = res_second[RES_WIDTH-1:SAMPLE_WIDTH-1];
        clip_first  = !((&top_first) || !(|top_first));
        clip_second = !((&top_second) || !(|top_second));

        if (clip_first)
        begin
            first_next = res_first[RES_WIDTH-1] ? SAT_MIN : SAT_MAX;
        end
        else
        begin
            first_next = res_first[SAMPLE_WIDTH-1:0];
        end

        if (!ctrl_b_reg.partner)
        begin
            second_next = '0;
        end
        else if (clip_second)
        begin
            second_next = res_second[RES_WIDTH-1] ? SAT_MIN : SAT_MAX;
        end
        else
        begin
            second_next = res_second[SAMPLE_WIDTH-1:0];
        end

        sat_next = clip_first || (ctrl_b_reg.partner && clip_second);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_a_reg <= '0;
            ctrl_b_reg <= '0;
            ctrl_c_reg <= '0;
        end
        else if (advance)
        begin
            ctrl_a_reg <= ctrl_up;
            ctrl_b_reg <= ctrl_a_reg;
            ctrl_c_reg <= ctrl_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cos_a_reg      <= ctrl_up.flip ? -cos_up : cos_up;
            sin_a_reg      <= ctrl_up.flip ? -sin_up : sin_up;
            first_a_reg    <= first_up;
            second_a_reg   <= second_up;
            first_cos_reg  <= PROD_WIDTH'(first_a_reg) * PROD_WIDTH'(cos_a_reg);
            first_sin_reg  <= PROD_WIDTH'(first_a_reg) * PROD_WIDTH'(sin_a_reg);
            second_cos_reg <= PROD_WIDTH'(second_a_reg) * PROD_WIDTH'(cos_a_reg);
            second_sin_reg <= PROD_WIDTH'(second_a_reg) * PROD_WIDTH'(sin_a_reg);
            first_c_reg    <= first_next;
            second_c_reg   <= second_next;
            sat_c_reg      <= sat_next;
        end
    end

    assign valid_dn       = ctrl_c_reg.valid;
    assign rotated_first  = first_c_reg;
    assign rotated_second = second_c_reg;
    assign partner_valid  = ctrl_c_reg.partner;
    assign saturated      = sat_c_reg;
    assign end_of_vector  = ctrl_c_reg.last;

endmodule

// ===== hdl/prp_skid.sv =====
// ----------------------------------------------------------------------------
// Output skid buffer
// Two-entry output register that keeps the upstream ready signal registered
// and absorbs one item when the receiver stalls.
// ----------------------------------------------------------------------------
module prp_skid #(
    parameter int DATA_WIDTH = 35
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  up_valid,
    output logic                  up_ready,
    input  logic [DATA_WIDTH-1:0] up_data,
    output logic                  down_valid,
    input  logic                  down_ready,
    output logic [DATA_WIDTH-1:0] down_data
);
    logic                  valid_reg;
    logic                  valid_next;
    logic                  full_reg;
    logic                  full_next;
    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic [DATA_WIDTH-1:0] spare_reg;
    logic [DATA_WIDTH-1:0] spare_next;
    logic                  take;

    assign take = up_valid && !full_reg;

    always_comb
    begin
        valid_next = valid_reg;
        full_next  = full_reg;
        data_next  = data_reg;
        spare_next = spare_reg;
        priority if (take)
        begin
            if (!valid_reg || down_ready)
            begin
                data_next  = up_data;
                valid_next = 1'b1;
            end
            else
            begin
                spare_next = up_data;
                full_next  = 1'b1;
            end
        end
        else if (valid_reg && down_ready)
        begin
            if (full_reg)
            begin
                data_next = spare_reg;
                full_next = 1'b0;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
        else
        begin
            full_next = full_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            full_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            full_reg  <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        spare_reg <= spare_next;
    end

    assign up_ready   = !full_reg;
    assign down_valid = valid_reg;
    assign down_data  = data_reg;

    a_full_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg |-> valid_reg)
        else $error("Spare entry holds an item while the head is empty.");

    a_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full_reg) |-> $past(valid_reg && !down_ready && up_valid))
        else $error("Spare entry filled without a stalled head.");

    a_drain_on_ready: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(full_reg) |-> $past(down_ready) && valid_reg)
        else $error("Spare entry drained without a downstream transfer.");

endmodule

// ===== hdl/pairwise_planar_rotation.sv =====
// ----------------------------------------------------------------------------
// Pairwise planar rotation
// Rotates one coordinate pair by a binary angle using an unrolled CORDIC
// chain for cosine and sine, then a multiply, round and saturate back end.
//
// The pair channel takes one item per cycle while pair.ready is high: two
// Q1.15 coordinates, a binary angle where the full range is one turn, a
// partner flag and an end-of-vector mark. Without a partner the first
// coordinate is scaled by the cosine and the second result is zero. The
// result channel returns the rotated pair, the partner flag, a saturation
// flag and the end mark. A result passes one register per CORDIC cell,
// three back-end stages and the output register. Throughput is one item
// per cycle while the output buffer has room. Reset empties the pipeline
// and the output buffer. When the receiver stalls, the output buffer holds
// one more item; once it is full, the pipeline freezes and pair.ready falls
// until the receiver takes an item.
// ----------------------------------------------------------------------------
module pairwise_planar_rotation #(
    parameter int SAMPLE_WIDTH  = 16,
    parameter int ANGLE_WIDTH   = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    prp_pair_if.sink     pair,
    prp_result_if.source result
);
    import prp_pkg::*;

    localparam int DATA_WIDTH = 2 * SAMPLE_WIDTH + 3;
    localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MAX = ~SAT_MIN;

    logic                           advance;
    logic [CORDIC_WIDTH-1:0]        angle_turn;
    logic signed [CORDIC_WIDTH-1:0] angle_signed;
    logic                           flip;

    ctrl_t                          ctrl_chain   [CORDIC_STAGES+1];
    logic signed [CORDIC_WIDTH-1:0] x_chain      [CORDIC_STAGES+1];
    logic signed [CORDIC_WIDTH-1:0] y_chain      [CORDIC_STAGES+1];
    logic signed [CORDIC_WIDTH-1:0] z_chain      [CORDIC_STAGES+1];
    logic signed [SAMPLE_WIDTH-1:0] first_chain  [CORDIC_STAGES+1];
    logic signed [SAMPLE_WIDTH-1:0] second_chain [CORDIC_STAGES+1];

    logic                           rot_valid;
    logic signed [SAMPLE_WIDTH-1:0] rot_first;
    logic signed [SAMPLE_WIDTH-1:0] rot_second;
    logic                           rot_partner;
    logic                           rot_sat;
    logic                           rot_last;
    logic [DATA_WIDTH-1:0]          skid_in;
    logic [DATA_WIDTH-1:0]          skid_out;

    // Angles beyond a quarter turn are moved by half a turn, which flips the
    // top bit, and the CORDIC outputs are negated later.
    always_comb
    begin
        angle_turn   = CORDIC_WIDTH'(unsigned'(pair.rotation_angle)) << (CORDIC_WIDTH - ANGLE_WIDTH);
        angle_signed = signed'(angle_turn);
        flip         = (angle_signed > QUARTER_TURN) || (angle_signed < -QUARTER_TURN);

        ctrl_chain[0].valid   = pair.valid;
        ctrl_chain[0].flip    = flip;
        ctrl_chain[0].partner = pair.has_partner;
        ctrl_chain[0].last    = pair.last_of_vector;
        x_chain[0]            = GAIN_Q30;
        y_chain[0]            = '0;
        z_chain[0]            = flip ? signed'({~angle_turn[CORDIC_WIDTH-1],
                                                angle_turn[CORDIC_WIDTH-2:0]})
                                     : angle_signed;
        first_chain[0]        = pair.first_value;
        second_chain[0]       = pair.has_partner ? pair.second_value : '0;
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cell
        prp_cordic_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .SHIFT        (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .ctrl_up   (ctrl_chain[i]),
            .x_up      (x_chain[i]),
            .y_up      (y_chain[i]),
            .z_up      (z_chain[i]),
            .first_up  (first_chain[i]),
            .second_up (second_chain[i]),
            .ctrl_dn   (ctrl_chain[i+1]),
            .x_dn      (x_chain[i+1]),
            .y_dn      (y_chain[i+1]),
            .z_dn      (z_chain[i+1]),
            .first_dn  (first_chain[i+1]),
            .second_dn (second_chain[i+1])
        );
    end

    prp_rotate #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_rotate (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .ctrl_up        (ctrl_chain[CORDIC_STAGES]),
        .cos_up         (x_chain[CORDIC_STAGES]),
        .sin_up         (y_chain[CORDIC_STAGES]),
        .first_up       (first_chain[CORDIC_STAGES]),
        .second_up      (second_chain[CORDIC_STAGES]),
        .valid_dn       (rot_valid),
        .rotated_first  (rot_first),
        .rotated_second (rot_second),
        .partner_valid  (rot_partner),
        .saturated      (rot_sat),
        .end_of_vector  (rot_last)
    );

    assign skid_in = {rot_first, rot_second, rot_partner, rot_sat, rot_last};

    prp_skid #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_skid (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (rot_valid),
        .up_ready   (advance),
        .up_data    (skid_in),
        .down_valid (result.valid),
        .down_ready (result.ready),
        .down_data  (skid_out)
    );

    assign pair.ready            = advance;
    assign result.rotated_first  = skid_out[DATA_WIDTH-1:SAMPLE_WIDTH+3];
    assign result.rotated_second = skid_out[SAMPLE_WIDTH+2:3];
    assign result.partner_valid  = skid_out[2];
    assign result.saturated      = skid_out[1];
    assign result.end_of_vector  = skid_out[0];

    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        !pair.ready |-> result.valid)
        else $error("Input stalled while no result is waiting.");

    a_unpaired_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.partner_valid |-> result.rotated_second == '0)
        else $error("Unpaired item returned a nonzero second coordinate.");

    a_saturated_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.saturated |->
            result.rotated_first == SAT_MAX || result.rotated_first == SAT_MIN ||
            result.rotated_second == SAT_MAX || result.rotated_second == SAT_MIN)
        else $error("Saturation flag set without a coordinate at a range limit.");

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// Pairwise planar rotation testbench
// Drives coordinate pairs with directed corner cases, then with random
// vectors and noise items. Each accepted item is predicted by a CORDIC
// model kept in a scoreboard class, and each returned item is compared
// field by field. Both channels idle at random, and the result side
// holds off long enough to fill the pipeline and stall the input.
// ----------------------------------------------------------------------------
module testbench;

    import prp_pkg::*;

    localparam int SW     = 16;
    localparam int AW     = 16;
    localparam int STAGES = 16;

    typedef struct {
        logic signed [SW-1:0] first;
        logic signed [SW-1:0] second;
        logic                 partner;
        logic                 clipped;
        logic                 last;
    } rotation_t;

    class rotation_scoreboard;
        rotation_t pending_rotations[$];
        int        error_count = 0;

        task report_mismatch(string what, longint got, longint want);
            $display("mismatch %s: got %0d expected %0d", what, got, want);
            error_count++;
        endtask

        function logic signed [SW-1:0] round_clip(input longint acc, inout logic clip);
            longint hi;
            longint lo;
            longint r;
            hi = (longint'(1) <<< (SW - 1)) - 1;
            lo = -(longint'(1) <<< (SW - 1));
            r  = (acc + (longint'(1) <<< 29)) >>> FRAC_BITS;
            if (r > hi)
            begin
                clip = 1'b1;
                r    = hi;
            end
            else if (r < lo)
            begin
                clip = 1'b1;
                r    = lo;
            end
            return r[SW-1:0];
        endfunction

        function rotation_t rotate_pair(logic signed [SW-1:0] x1, logic signed [SW-1:0] x2,
                                        logic signed [AW-1:0] angle, logic partner,
                                        logic last);
            rotation_t                   res;
            logic signed [CORDIC_WIDTH-1:0] turn;
            longint                      z;
            longint                      cx;
            longint                      sy;
            longint                      dx;
            longint                      dy;
            logic                        flip;
            logic                        clip;
            int                          n;
            turn = {angle, {(CORDIC_WIDTH - AW){1'b0}}};
            z    = longint'(turn);
            flip = 1'b0;
            if (z > longint'(QUARTER_TURN))
            begin
                z    = z - 64'sd2147483648;
                flip = 1'b1;
            end
            else if (z < -longint'(QUARTER_TURN))
            begin
                z    = z + 64'sd2147483648;
                flip = 1'b1;
            end
            cx = longint'(GAIN_Q30);
            sy = 0;
            n  = (STAGES > MAX_STAGES) ? MAX_STAGES : STAGES;
            for (int i = 0; i < n; i++)
            begin
                dx = sy >>> i;
                dy = cx >>> i;
                if (z >= 0)
                begin
                    cx = cx - dx;
                    sy = sy + dy;
                    z  = z - longint'(ATAN_TURN32[i]);
                end
                else
                begin
                    cx = cx + dx;
                    sy = sy - dy;
                    z  = z + longint'(ATAN_TURN32[i]);
                end
            end
            if (flip)
            begin
                cx = -cx;
                sy = -sy;
            end
            clip = 1'b0;
            if (partner)
            begin
                res.first  = round_clip(longint'(x1) * cx - longint'(x2) * sy, clip);
                res.second = round_clip(longint'(x1) * sy + longint'(x2) * cx, clip);
            end
            else
            begin
                res.first  = round_clip(longint'(x1) * cx, clip);
                res.second = '0;
            end
            res.partner = partner;
            res.clipped = clip;
            res.last    = last;
            return res;
        endfunction

        function void note_pair(logic signed [SW-1:0] x1, logic signed [SW-1:0] x2,
                                logic signed [AW-1:0] angle, logic partner, logic last);
            pending_rotations.insert(pending_rotations.size(),
                                     rotate_pair(x1, x2, angle, partner, last));
        endfunction

        task check_result(rotation_t got);
            rotation_t want;
            if (pending_rotations.size() == 0)
            begin
                report_mismatch("unexpected result, rotated_first", got.first, 0);
            end
            else
            begin
                want = pending_rotations.pop_front();
                if (got.first !== want.first)
                    report_mismatch("rotated_first", got.first, want.first);
                if (got.second !== want.second)
                    report_mismatch("rotated_second", got.second, want.second);
                if (got.partner !== want.partner)
                    report_mismatch("partner_valid", got.partner, want.partner);
                if (got.clipped !== want.clipped)
                    report_mismatch("saturated", got.clipped, want.clipped);
                if (got.last !== want.last)
                    report_mismatch("end_of_vector", got.last, want.last);
            end
        endtask
    endclass

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   hold_cycles;
    int   items_sent;

    rotation_scoreboard rotation_check = new();

    prp_pair_if #(.SAMPLE_WIDTH(SW), .ANGLE_WIDTH(AW)) pair_ch();
    prp_result_if #(.SAMPLE_WIDTH(SW)) result_ch();

    pairwise_planar_rotation #(
        .SAMPLE_WIDTH  (SW),
        .ANGLE_WIDTH   (AW),
        .CORDIC_STAGES (STAGES)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .pair   (pair_ch.sink),
        .result (result_ch.source)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        rotation_t got;
        if (rst_n && pair_ch.valid && pair_ch.ready)
            rotation_check.note_pair(pair_ch.first_value, pair_ch.second_value,
                                     pair_ch.rotation_angle, pair_ch.has_partner,
                                     pair_ch.last_of_vector);
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.first   = result_ch.rotated_first;
            got.second  = result_ch.rotated_second;
            got.partner = result_ch.partner_valid;
            got.clipped = result_ch.saturated;
            got.last    = result_ch.end_of_vector;
            rotation_check.check_result(got);
        end
    end

    // The receiver holds off while hold_cycles counts down whenever the stimulus asks.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_cycles = hold_cycles - 1;
            end
            else
            begin
                result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task send_pair(logic signed [SW-1:0] x1, logic signed [SW-1:0] x2,
                   logic signed [AW-1:0] angle, logic partner, logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            pair_ch.valid <= 1'b0;
            @(posedge clk);
        end
        @(negedge clk);
        pair_ch.valid          <= 1'b1;
        pair_ch.first_value    <= x1;
        pair_ch.second_value   <= x2;
        pair_ch.rotation_angle <= angle;
        pair_ch.has_partner    <= partner;
        pair_ch.last_of_vector <= last;
        do
            @(posedge clk);
        while (!pair_ch.ready);
        items_sent++;
    endtask

    function logic signed [SW-1:0] random_sample();
        unique case ($urandom_range(15))
            0:       return {1'b0, {(SW - 1){1'b1}}};
            1:       return {1'b1, {(SW - 1){1'b0}}};
            2:       return '0;
            3:       return '1;
            default: return SW'($urandom);
        endcase
    endfunction

    function logic signed [AW-1:0] random_angle();
        logic signed [AW-1:0] quarter;
        quarter = AW'(1) <<< (AW - 2);
        unique case ($urandom_range(11))
            0:       return quarter;
            1:       return AW'(quarter + 1);
            2:       return -quarter;
            3:       return AW'(-quarter - 1);
            4:       return {1'b1, {(AW - 1){1'b0}}};
            5:       return {1'b0, {(AW - 1){1'b1}}};
            6:       return AW'(0);
            default: return AW'($urandom);
        endcase
    endfunction

    task send_vector();
        int                   len;
        logic signed [AW-1:0] angle;
        angle = random_angle();
        len   = $urandom_range(1, 8);
        for (int k = 0; k < len; k += 2)
        begin
            if ($urandom_range(7) == 0)
                send_pair(random_sample(), random_sample(), random_angle(),
                          1'($urandom), 1'($urandom));
            else
                send_pair(random_sample(), random_sample(), angle,
                          (k + 1 < len), (k + 2 >= len));
        end
    endtask

    task run_random(int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
            send_vector();
    endtask

    initial
    begin
        clk                    = 1'b0;
        rst_n                  = 1'b0;
        hold_cycles            = 0;
        items_sent             = 0;
        send_idle_pct          = 14;
        recv_idle_pct          = 54;
        pair_ch.valid          = 1'b0;
        pair_ch.first_value    = '0;
        pair_ch.second_value   = '0;
        pair_ch.rotation_angle = '0;
        pair_ch.has_partner    = 1'b0;
        pair_ch.last_of_vector = 1'b0;
        result_ch.ready        = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_pair(16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1);
        send_pair(16'sd32767, 16'sd0, 16'sd0, 1'b1, 1'b0);
        send_pair(-16'sd32768, -16'sd32768, 16'sd8192, 1'b1, 1'b0);
        send_pair(16'sd32767, 16'sd32767, 16'sd8192, 1'b1, 1'b0);
        send_pair(16'sd32767, -16'sd32768, -16'sd8192, 1'b1, 1'b1);
        send_pair(16'sd20000, -16'sd12000, 16'sd16384, 1'b1, 1'b0);
        send_pair(16'sd20000, -16'sd12000, 16'sd16385, 1'b1, 1'b0);
        send_pair(-16'sd32768, 16'sd32767, -16'sd16384, 1'b1, 1'b0);
        send_pair(-16'sd32768, 16'sd32767, -16'sd16385, 1'b1, 1'b1);
        send_pair(16'sd32767, 16'sd32767, -16'sd32768, 1'b1, 1'b0);
        send_pair(-16'sd32768, 16'sd1, 16'sd32767, 1'b1, 1'b0);
        send_pair(-16'sd1, 16'sd1, -16'sd24576, 1'b1, 1'b1);
        send_pair(16'sd32767, 16'sd12345, 16'sd0, 1'b0, 1'b1);
        send_pair(-16'sd32768, -16'sd1, -16'sd32768, 1'b0, 1'b1);
        send_pair(16'sd32767, 16'sd0, 16'sd4096, 1'b0, 1'b0);
        send_pair(-16'sd32768, -16'sd32768, 16'sd2, 1'b0, 1'b1);

        hold_cycles = 70;
        run_random(120);

        send_idle_pct = 54;
        recv_idle_pct = 14;
        run_random(130);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles   = 80;
        run_random(150);

        @(negedge clk);
        pair_ch.valid <= 1'b0;
        while (rotation_check.pending_rotations.size() != 0)
            @(posedge clk);
        repeat (STAGES + 10) @(posedge clk);
        if (rotation_check.error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
